### design/mqsb_pkg.sv
// Package for the multi-queue shared buffer: sizes, status codes, payload
// structs, link memory entry type and the control state type.
// No dependencies.
`default_nettype none

package mqsb_pkg;

   localparam int SLOTS  = 64;
   localparam int QUEUES = 4;
   localparam int SLOT_W = $clog2(SLOTS);

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic signed [31:0] DATA_NONE = -32'sd1;

   typedef struct packed {
      logic              opcode;
      logic [1:0]        queue_id;
      logic signed [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data_out;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] next;
   } link_entry_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // Value held by a link entry that has never been written: the initial
   // free chain, each slot pointing at the one after it.
   function automatic link_entry_type link_reset_value(input logic [SLOT_W-1:0] idx);
      link_entry_type e;
      e.next  = idx + SLOT_W'(1);
      e.valid = (idx != SLOT_W'(SLOTS - 1));
      return e;
   endfunction

endpackage

`default_nettype wire

### design/multi_queue_shared_buffer.sv
// Multi-queue shared buffer: several FIFO queues in one slot store, with a
// linked free list. Depends on mqsb_pkg.
// Timing: a req transfer is registered and committed in the EXEC state,
// which raises rsp_valid; a stalled result holds in the output register
// while the next request is taken, and the next commit waits for it.
// One request at a time: link memory read at transfer, written back at commit.
// Reset: synchronous; queue and free-list registers clear, link entries
// read as the initial free chain until first written, so no clearing pass.
`default_nettype none

module multi_queue_shared_buffer (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  mqsb_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output mqsb_pkg::rsp_type    rsp_payload
);
   import mqsb_pkg::*;

   state_type state_ff, state_in;

   logic [SLOT_W-1:0] head_ff [QUEUES];
   logic [SLOT_W-1:0] head_in [QUEUES];
   logic [SLOT_W-1:0] tail_ff [QUEUES];
   logic [SLOT_W-1:0] tail_in [QUEUES];
   logic [QUEUES-1:0] nonempty_ff, nonempty_in;
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic              free_nonempty_ff, free_nonempty_in;

   // item in flight
   logic              op_ff;
   logic [1:0]        q_ff;
   logic              act_ff;
   logic [SLOT_W-1:0] idx_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // memories
   link_entry_type    link_mem [SLOTS];
   logic [31:0]       data_mem [SLOTS];
   logic [SLOTS-1:0]  link_written_ff;
   link_entry_type    link_rd_ff;
   logic              link_rd_written_ff;
   logic [31:0]       data_rd_ff;

   logic              req_fire;
   logic              commit;
   logic              q_ok;
   logic              rd_act;
   logic [SLOT_W-1:0] rd_idx;
   link_entry_type    link_q;
   logic              link_we;
   logic [SLOT_W-1:0] link_waddr;
   link_entry_type    link_wdata;

   assign req_fire = req_valid && req_ready;
   assign q_ok     = 32'(req_payload.queue_id) < QUEUES;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_fire) state_in = S_EXEC;
         S_EXEC: if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_EXEC: commit = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // decide the slot at transfer time
   always_comb begin
      if (req_payload.opcode == OP_ENQ) begin
         rd_idx = free_head_ff;
         rd_act = q_ok && free_nonempty_ff;
      end else begin
         rd_idx = head_ff[req_payload.queue_id];
         rd_act = q_ok && nonempty_ff[req_payload.queue_id];
      end
   end

   assign link_q = link_rd_written_ff ? link_rd_ff : link_reset_value(idx_ff);

   // commit: write back queue and free-list state, build the result
   always_comb begin
      head_in          = head_ff;
      tail_in          = tail_ff;
      nonempty_in      = nonempty_ff;
      free_head_in     = free_head_ff;
      free_nonempty_in = free_nonempty_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      link_we          = 1'b0;
      link_waddr       = idx_ff;
      link_wdata       = link_q;
      if (commit) begin
         rsp_valid_in = 1'b1;
         if (op_ff == OP_ENQ) begin
            rsp_in.data_out = '0;
            if (act_ff) begin
               rsp_in.status    = STATUS_OK;
               free_head_in     = link_q.next;
               free_nonempty_in = link_q.valid;
               if (nonempty_ff[q_ff]) begin
                  link_we          = 1'b1;
                  link_waddr       = tail_ff[q_ff];
                  link_wdata.valid = 1'b1;
                  link_wdata.next  = idx_ff;
               end else begin
                  head_in[q_ff]     = idx_ff;
                  nonempty_in[q_ff] = 1'b1;
               end
               tail_in[q_ff] = idx_ff;
            end else begin
               rsp_in.status = STATUS_FULL;
            end
         end else begin
            if (act_ff) begin
               rsp_in.status     = STATUS_OK;
               rsp_in.data_out   = data_rd_ff;
               // the tail is the only entry without a successor
               nonempty_in[q_ff] = (idx_ff != tail_ff[q_ff]);
               head_in[q_ff]     = link_q.next;
               link_we           = 1'b1;
               link_waddr        = idx_ff;
               link_wdata.valid  = free_nonempty_ff;
               link_wdata.next   = free_head_ff;
               free_head_in      = idx_ff;
               free_nonempty_in  = 1'b1;
            end else begin
               rsp_in.status   = STATUS_EMPTY;
               rsp_in.data_out = DATA_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         nonempty_ff      <= '0;
         free_head_ff     <= '0;
         free_nonempty_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         link_written_ff  <= '0;
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff         <= state_in;
         nonempty_ff      <= nonempty_in;
         free_head_ff     <= free_head_in;
         free_nonempty_ff <= free_nonempty_in;
         rsp_valid_ff     <= rsp_valid_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         if (link_we) link_written_ff[link_waddr] <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_fire) begin
         op_ff              <= req_payload.opcode;
         q_ff               <= req_payload.queue_id;
         act_ff             <= rd_act;
         idx_ff             <= rd_idx;
         link_rd_written_ff <= link_written_ff[rd_idx];
      end
   end

   // link memory: read at transfer, write back at commit
   always_ff @(posedge clock) begin
      if (req_fire) link_rd_ff <= link_mem[rd_idx];
      if (link_we) link_mem[link_waddr] <= link_wdata;
   end

   // slot data memory: enqueue writes at transfer, dequeue reads at transfer
   always_ff @(posedge clock) begin
      if (req_fire && rd_act && req_payload.opcode == OP_ENQ)
         data_mem[rd_idx] <= req_payload.data_in;
      if (req_fire) data_rd_ff <= data_mem[rd_idx];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_fire_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_EXEC)
      else $error("request transfer did not start execution");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result raised without a commit");

   a_link_write_exec: assert property (@(posedge clock) disable iff (reset)
      link_we |-> state_ff == S_EXEC && act_ff)
      else $error("link write outside an active commit");

   a_deq_frees: assert property (@(posedge clock) disable iff (reset)
      commit && act_ff && op_ff == OP_DEQ |=> free_nonempty_ff && free_head_ff == $past(idx_ff))
      else $error("dequeued slot not returned to free list");

endmodule

`default_nettype wire

### tb/multi_queue_shared_buffer_tb.sv
// Testbench for multi_queue_shared_buffer: a directed and random mix of
// enqueues and dequeues, checked against an in-bench model of the queues and
// free list. Depends on mqsb_pkg and the multi_queue_shared_buffer RTL.
`default_nettype none

module multi_queue_shared_buffer_tb;
   import mqsb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_TOTAL  = 1800;
   localparam int PHASE_LEN  = 600;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      sent_count = 0;
   int      error_count = 0;
   logic    req_taken = 1'b0;
   logic    hold_output = 1'b0;

   // Model of the queues and the free list
   logic [SLOT_W-1:0]  q_head [QUEUES];
   logic [SLOT_W-1:0]  q_tail [QUEUES];
   logic               q_busy [QUEUES];
   logic [SLOT_W-1:0]  link_next [SLOTS];
   logic               link_more [SLOTS];
   logic signed [31:0] slot_value [SLOTS];
   logic [SLOT_W-1:0]  free_slot;
   logic               free_more;

   multi_queue_shared_buffer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic apply_request(input req_type r, output rsp_type e);
      int                q;
      logic [SLOT_W-1:0] s;
      q = int'(r.queue_id);
      e.data_out = '0;
      e.status   = STATUS_OK;
      if (r.opcode == OP_ENQ) begin
         if (q >= QUEUES || !free_more) begin
            e.status = STATUS_FULL;
         end else begin
            s         = free_slot;
            free_slot = link_next[s];
            free_more = link_more[s];
            if (q_busy[q]) begin
               link_next[q_tail[q]] = s;
               link_more[q_tail[q]] = 1'b1;
            end else begin
               q_head[q] = s;
               q_busy[q] = 1'b1;
            end
            link_next[s]  = '0;
            link_more[s]  = 1'b0;
            q_tail[q]     = s;
            slot_value[s] = r.data_in;
         end
      end else begin
         if (q >= QUEUES || !q_busy[q]) begin
            e.data_out = DATA_NONE;
            e.status   = STATUS_EMPTY;
         end else begin
            s            = q_head[q];
            q_busy[q]    = link_more[s];
            q_head[q]    = link_next[s];
            link_next[s] = free_slot;
            link_more[s] = free_more;
            free_slot    = s;
            free_more    = 1'b1;
            e.data_out   = slot_value[s];
         end
      end
   endtask

   function automatic void add_request(input logic op, input int q,
                                       input logic signed [31:0] d);
      req_type r;
      r.opcode   = op;
      r.queue_id = q[1:0];
      r.data_in  = d;
      pending_reqs.push_back(r);
   endfunction

   function automatic int sender_gap_pct();
      if (sent_count < PHASE_LEN) return 26;
      if (sent_count < 2 * PHASE_LEN) return 77;
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (sent_count < PHASE_LEN) return 77;
      if (sent_count < 2 * PHASE_LEN) return 26;
      return 0;
   endfunction

   // Request driver: hold the item until its transfer, then maybe idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct()) begin
            req_payload <= pending_reqs.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_output && ($urandom_range(0, 99) >= receiver_stall_pct());
      end
   end

   // Monitor: check responses first, then predict for the accepted request
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with nothing outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.data_out !== want.data_out)
                  report_mismatch($sformatf("data_out %h, expected %h",
                                            rsp_payload.data_out, want.data_out));
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_payload.status, want.status));
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_payload, want);
            expected_rsps.push_back(want);
            sent_count <= sent_count + 1;
         end
      end
   end

   // Long receiver hold-off so the output register stays full and the block stalls its input
   initial begin
      while (sent_count < 250) @(posedge clock);
      hold_output = 1'b1;
      repeat (400) @(posedge clock);
      hold_output = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int                 wave_len;
      int                 enq_pct;
      int                 focus;
      int                 q;
      logic               op;
      logic signed [31:0] d;
      int                 bias [6];

      for (int i = 0; i < QUEUES; i++) begin
         q_head[i] = '0;
         q_tail[i] = '0;
         q_busy[i] = 1'b0;
      end
      for (int i = 0; i < SLOTS; i++) begin
         link_next[i]  = SLOT_W'(i + 1);
         link_more[i]  = (i != SLOTS - 1);
         slot_value[i] = '0;
      end
      free_slot = '0;
      free_more = 1'b1;

      // Directed: empty queues, data extremes, last element leaving
      for (int i = 0; i < QUEUES; i++) add_request(OP_DEQ, i, '0);
      add_request(OP_ENQ, 0, 32'sh8000_0000);
      add_request(OP_ENQ, 0, 32'sh7fff_ffff);
      add_request(OP_ENQ, 1, 32'sh0000_0000);
      add_request(OP_ENQ, 2, -32'sd1);
      add_request(OP_ENQ, 3, 32'sh5a5a_a5a5);
      add_request(OP_DEQ, 0, 32'sh1234_5678);
      add_request(OP_DEQ, 0, '0);
      add_request(OP_DEQ, 0, '0);
      add_request(OP_DEQ, 1, -32'sd1);
      add_request(OP_ENQ, 1, 32'sd123);
      add_request(OP_ENQ, 1, 32'sd456);
      add_request(OP_DEQ, 1, '0);
      add_request(OP_DEQ, 2, '0);
      add_request(OP_DEQ, 3, '0);
      add_request(OP_DEQ, 1, '0);
      add_request(OP_DEQ, 1, '0);

      // Random waves biased to fill the store up and drain it again
      bias = '{95, 10, 60, 40, 85, 5};
      while (pending_reqs.size() < REQ_TOTAL) begin
         wave_len = $urandom_range(40, 130);
         enq_pct  = bias[$urandom_range(0, 5)];
         focus    = $urandom_range(0, QUEUES);
         for (int n = 0; n < wave_len; n++) begin
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
            if (focus < QUEUES && $urandom_range(0, 99) < 70) q = focus;
            else q = $urandom_range(0, QUEUES - 1);
            case ($urandom_range(0, 15))
               0:       d = 32'sh8000_0000;
               1:       d = 32'sh7fff_ffff;
               2:       d = '0;
               3:       d = -32'sd1;
               default: d = $urandom;
            endcase
            add_request(op, q, d);
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
